// File: design/eik_pkg.sv
// eik_pkg: shared types and constants of the eikonal cell update block
`timescale 1ns / 1ps
package eik_pkg;

  localparam int VAL_W = 40;
  localparam int CW_W = 24;

  // pipeline layout
  localparam int SQRT_STEPS = 25;
  localparam int DIV_STEPS = 26;
  localparam int SQ_BASE = 4;
  localparam int MUL_BASE = SQ_BASE + SQRT_STEPS;
  localparam int DIV_BASE = MUL_BASE + 4;
  localparam int FIN_BASE = DIV_BASE + DIV_STEPS;
  localparam int NUM_STAGES = FIN_BASE + 3;

  localparam logic [CW_W-1:0] CW_RESET = 24'd65536;

  // register index carried by paddr[2]
  localparam logic REG_X = 1'b0;
  localparam logic REG_Y = 1'b1;

  // outcome codes
  localparam logic [1:0] OUT_ROOT = 2'd0;
  localparam logic [1:0] OUT_KEPT = 2'd1;
  localparam logic [1:0] OUT_NONE = 2'd2;

  localparam logic signed [VAL_W+1:0] VAL_MAX = 42'sd549755813887;
  localparam logic signed [VAL_W+1:0] VAL_MIN = -42'sd549755813888;

  typedef struct packed {
    logic signed [VAL_W-1:0] centre_value;
    logic signed [VAL_W-1:0] left_value;
    logic signed [VAL_W-1:0] right_value;
    logic signed [VAL_W-1:0] below_value;
    logic signed [VAL_W-1:0] above_value;
  } cell_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] new_value;
    logic [1:0]              outcome;
  } result_t;

  // per-item context carried alongside the arithmetic
  typedef struct packed {
    logic signed [VAL_W-1:0] cur;
    logic signed [VAL_W-1:0] py;
    logic                    dneg;
    logic                    two_axis;
    logic                    mzero;
    logic signed [VAL_W:0]   fb_hi;
    logic signed [VAL_W:0]   fb_lo;
    logic [24:0]             dmag;
  } side_t;

endpackage

// File: design/eikonal_cell_update_2d_core.sv
// eikonal_cell_update_2d_core: pipelined 2-d eikonal local update of one grid cell
`timescale 1ns / 1ps
// a result passes through 62 register stages, from the item-in stage to the output register
// throughput: one item per cycle unless a full pipeline is stalled; the 25-stage square root and
//   the 26-stage restoring divider each resolve one result bit per stage, setting the pipeline depth
// stalls back up stage by stage, so empty stages still take items while a result waits
// reset: synchronous rst empties the pipeline and sets both spacings to 1.0; the spacing
//   products are registered from the spacing registers, and msum from those products
module eikonal_cell_update_2d_core import eik_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cell_valid,
  output logic        cell_stall,
  input  cell_t       cell_data,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  function automatic logic [VAL_W-1:0] mag40(input logic signed [VAL_W-1:0] x);
    mag40 = x[VAL_W-1] ? (~x + 1'b1) : x;
  endfunction

  function automatic logic signed [VAL_W-1:0] sat40(input logic signed [VAL_W+1:0] x);
    if (x > VAL_MAX) sat40 = VAL_MAX[VAL_W-1:0];
    else if (x < VAL_MIN) sat40 = VAL_MIN[VAL_W-1:0];
    else sat40 = x[VAL_W-1:0];
  endfunction

  // ---------------------------------------------------------------- config
  logic [CW_W-1:0] cwx, cwy;
  logic [47:0]     xsq, ysq, dxdy;
  logic [48:0]     msum;

  assign pready = 1'b1;
  assign prdata = {8'd0, (paddr[2] == REG_Y) ? cwy : cwx};

  always_ff @(posedge clk) begin
    if (rst) begin
      cwx <= CW_RESET;
      cwy <= CW_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_X:   cwx <= pwdata[CW_W-1:0];
        REG_Y:   cwy <= pwdata[CW_W-1:0];
        default: cwx <= cwx;
      endcase
    end
  end

  // spacing products; the user must keep them static while items are in flight (not enforced)
  always_ff @(posedge clk) begin
    xsq  <= 48'(cwx) * 48'(cwx);
    ysq  <= 48'(cwy) * 48'(cwy);
    dxdy <= 48'(cwx) * 48'(cwy);
    msum <= 49'(xsq) + 49'(ysq);
  end

  // ---------------------------------------------------------------- flow control
  logic [NUM_STAGES-1:0] v, en, vin;

  // a stage moves when the output is free or some stage at or after it is empty
  always_comb begin
    logic [NUM_STAGES-1:0] lm;
    for (int i = 0; i < NUM_STAGES; i++) begin
      lm = (NUM_STAGES'(1) << i) - NUM_STAGES'(1);
      en[i] = !(result_stall && ((v | lm) == '1));
    end
  end

  assign vin = {v[NUM_STAGES-2:0], cell_valid};
  assign cell_stall = !en[0];
  assign result_valid = v[NUM_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int i = 0; i < NUM_STAGES; i++) begin
        if (en[i]) v[i] <= vin[i];
      end
    end
  end

  // ---------------------------------------------------------------- stage 0: item in
  cell_t s0;
  always_ff @(posedge clk) begin
    if (en[0]) s0 <= cell_data;
  end

  // ---------------------------------------------------------------- stage 1: upwind pick
  logic signed [VAL_W-1:0] b_cur, b_px, b_py, px_c, py_c;
  logic signed [VAL_W:0]   b_d;
  logic                    pos_c;

  always_comb begin
    pos_c = s0.centre_value > 0;
    if (pos_c) begin
      px_c = (s0.left_value < s0.right_value) ? s0.left_value : s0.right_value;
      py_c = (s0.below_value < s0.above_value) ? s0.below_value : s0.above_value;
    end else begin
      px_c = (s0.left_value > s0.right_value) ? s0.left_value : s0.right_value;
      py_c = (s0.below_value > s0.above_value) ? s0.below_value : s0.above_value;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      b_cur <= s0.centre_value;
      b_px  <= px_c;
      b_py  <= py_c;
      b_d   <= (VAL_W+1)'(px_c) - (VAL_W+1)'(py_c);
    end
  end

  // ---------------------------------------------------------------- stage 2: |d|, d^2, one-axis roots
  side_t       c_side, c_side_n;
  logic        c_small;
  logic [49:0] c_dsq;
  logic [VAL_W:0] dmag_full;
  logic        xdrop;

  always_comb begin
    dmag_full = b_d[VAL_W] ? (~b_d + 1'b1) : b_d;
    xdrop = mag40(b_px) > mag40(b_py);
    c_side_n.cur      = b_cur;
    c_side_n.py       = b_py;
    c_side_n.dneg     = b_d[VAL_W];
    c_side_n.two_axis = 1'b0;
    c_side_n.mzero    = 1'b0;
    c_side_n.dmag     = dmag_full[24:0];
    if (xdrop) begin
      c_side_n.fb_hi = (VAL_W+1)'(b_py) + $signed({17'd0, cwy});
      c_side_n.fb_lo = (VAL_W+1)'(b_py) - $signed({17'd0, cwy});
    end else begin
      c_side_n.fb_hi = (VAL_W+1)'(b_px) + $signed({17'd0, cwx});
      c_side_n.fb_lo = (VAL_W+1)'(b_px) - $signed({17'd0, cwx});
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      c_side  <= c_side_n;
      c_small <= (dmag_full[VAL_W:25] == '0);
      c_dsq   <= 50'(dmag_full[24:0]) * 50'(dmag_full[24:0]);
    end
  end

  // ---------------------------------------------------------------- stage 3: discriminant
  side_t       d_side, d_side_n;
  logic [49:0] d_rad;

  always_comb begin
    d_side_n          = c_side;
    d_side_n.two_axis = c_small && (c_dsq <= {1'b0, msum});
    d_side_n.mzero    = (msum == '0);
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      d_side <= d_side_n;
      d_rad  <= {1'b0, msum} - c_dsq;
    end
  end

  // ---------------------------------------------------------------- square root, 2 bits a stage
  side_t       sq_side [SQRT_STEPS];
  logic [49:0] sq_rad  [SQRT_STEPS];
  logic [26:0] sq_rem  [SQRT_STEPS];
  logic [24:0] sq_q    [SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    side_t       side_i;
    logic [49:0] rad_i;
    logic [26:0] rem_i;
    logic [24:0] q_i;
    logic [28:0] rs, t;

    if (k == 0) begin : g_first
      assign side_i = d_side;
      assign rad_i  = d_rad;
      assign rem_i  = '0;
      assign q_i    = '0;
    end else begin : g_rest
      assign side_i = sq_side[k-1];
      assign rad_i  = sq_rad[k-1];
      assign rem_i  = sq_rem[k-1];
      assign q_i    = sq_q[k-1];
    end

    assign rs = {rem_i, rad_i[49:48]};
    assign t  = {2'b00, q_i, 2'b01};

    always_ff @(posedge clk) begin
      if (en[SQ_BASE+k]) begin
        sq_side[k] <= side_i;
        sq_rad[k]  <= {rad_i[47:0], 2'b00};
        if (rs >= t) begin
          sq_rem[k] <= 27'(rs - t);
          sq_q[k]   <= {q_i[23:0], 1'b1};
        end else begin
          sq_rem[k] <= rs[26:0];
          sq_q[k]   <= {q_i[23:0], 1'b0};
        end
      end
    end
  end

  // ---------------------------------------------------------------- numerators
  side_t       m1_side, m2_side, m3_side, m4_side;
  logic [48:0] m1_p0, m1_p1, m1_q0, m1_q1;
  logic [72:0] m2_dy, m2_sq;
  logic signed [75:0] m3_nh, m3_nl, dys;
  logic [75:0] m4_ah, m4_al;
  logic        m4_neg_h, m4_neg_l;

  // partial products of |d|*dy^2 and dx*dy*root
  always_ff @(posedge clk) begin
    if (en[MUL_BASE]) begin
      m1_side <= sq_side[SQRT_STEPS-1];
      m1_p0   <= 49'(sq_side[SQRT_STEPS-1].dmag) * 49'(ysq[23:0]);
      m1_p1   <= 49'(sq_side[SQRT_STEPS-1].dmag) * 49'(ysq[47:24]);
      m1_q0   <= 49'(sq_q[SQRT_STEPS-1]) * 49'(dxdy[23:0]);
      m1_q1   <= 49'(sq_q[SQRT_STEPS-1]) * 49'(dxdy[47:24]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[MUL_BASE+1]) begin
      m2_side <= m1_side;
      m2_dy   <= 73'(m1_p0) + (73'(m1_p1) << 24);
      m2_sq   <= 73'(m1_q0) + (73'(m1_q1) << 24);
    end
  end

  assign dys = m2_side.dneg ? -$signed({3'b000, m2_dy}) : $signed({3'b000, m2_dy});

  always_ff @(posedge clk) begin
    if (en[MUL_BASE+2]) begin
      m3_side <= m2_side;
      m3_nh   <= dys + $signed({3'b000, m2_sq});
      m3_nl   <= dys - $signed({3'b000, m2_sq});
    end
  end

  always_ff @(posedge clk) begin
    if (en[MUL_BASE+3]) begin
      m4_side  <= m3_side;
      m4_neg_h <= m3_nh[75];
      m4_neg_l <= m3_nl[75];
      m4_ah    <= m3_nh[75] ? 76'(-m3_nh) : 76'(m3_nh);
      m4_al    <= m3_nl[75] ? 76'(-m3_nl) : 76'(m3_nl);
    end
  end

  // ---------------------------------------------------------------- restoring division, both roots
  side_t                dv_side [DIV_STEPS];
  logic [75:0]          dv_ph   [DIV_STEPS];
  logic [75:0]          dv_pl   [DIV_STEPS];
  logic [DIV_STEPS-1:0] dv_qh   [DIV_STEPS];
  logic [DIV_STEPS-1:0] dv_ql   [DIV_STEPS];
  logic                 dv_nh   [DIV_STEPS];
  logic                 dv_nl   [DIV_STEPS];

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    localparam int K = DIV_STEPS - 1 - j;
    side_t                side_i;
    logic [75:0]          ph_i, pl_i, trial;
    logic [DIV_STEPS-1:0] qh_i, ql_i;
    logic                 nh_i, nl_i;

    if (j == 0) begin : g_first
      assign side_i = m4_side;
      assign ph_i   = m4_ah;
      assign pl_i   = m4_al;
      assign qh_i   = '0;
      assign ql_i   = '0;
      assign nh_i   = m4_neg_h;
      assign nl_i   = m4_neg_l;
    end else begin : g_rest
      assign side_i = dv_side[j-1];
      assign ph_i   = dv_ph[j-1];
      assign pl_i   = dv_pl[j-1];
      assign qh_i   = dv_qh[j-1];
      assign ql_i   = dv_ql[j-1];
      assign nh_i   = dv_nh[j-1];
      assign nl_i   = dv_nl[j-1];
    end

    assign trial = 76'(msum) << K;

    always_ff @(posedge clk) begin
      if (en[DIV_BASE+j]) begin
        dv_side[j] <= side_i;
        dv_nh[j]   <= nh_i;
        dv_nl[j]   <= nl_i;
        if (ph_i >= trial) begin
          dv_ph[j] <= ph_i - trial;
          dv_qh[j] <= qh_i | (DIV_STEPS'(1) << K);
        end else begin
          dv_ph[j] <= ph_i;
          dv_qh[j] <= qh_i;
        end
        if (pl_i >= trial) begin
          dv_pl[j] <= pl_i - trial;
          dv_ql[j] <= ql_i | (DIV_STEPS'(1) << K);
        end else begin
          dv_pl[j] <= pl_i;
          dv_ql[j] <= ql_i;
        end
      end
    end
  end

  // ---------------------------------------------------------------- floor quotient sign
  localparam int LD = DIV_STEPS - 1;
  side_t              f1_side, f2_side;
  logic signed [27:0] f1_qh, f1_ql;
  logic [27:0]        qeh, qel;

  assign qeh = 28'(dv_qh[LD]) + 28'(dv_ph[LD] != '0);
  assign qel = 28'(dv_ql[LD]) + 28'(dv_pl[LD] != '0);

  always_ff @(posedge clk) begin
    if (en[FIN_BASE]) begin
      f1_side <= dv_side[LD];
      f1_qh   <= dv_nh[LD] ? $signed(-qeh) : $signed(28'(dv_qh[LD]));
      f1_ql   <= dv_nl[LD] ? $signed(-qel) : $signed(28'(dv_ql[LD]));
    end
  end

  // ---------------------------------------------------------------- roots, saturated
  logic signed [VAL_W-1:0] f2_hi, f2_lo;
  logic signed [VAL_W+1:0] rh, rl;

  always_comb begin
    if (f1_side.two_axis) begin
      rh = (VAL_W+2)'(f1_side.py) + (VAL_W+2)'(f1_qh);
      rl = (VAL_W+2)'(f1_side.py) + (VAL_W+2)'(f1_ql);
    end else begin
      rh = (VAL_W+2)'(f1_side.fb_hi);
      rl = (VAL_W+2)'(f1_side.fb_lo);
    end
  end

  always_ff @(posedge clk) begin
    if (en[FIN_BASE+1]) begin
      f2_side <= f1_side;
      f2_hi   <= sat40(rh);
      f2_lo   <= sat40(rl);
    end
  end

  // ---------------------------------------------------------------- pick and output register
  logic signed [VAL_W-1:0] pick;
  result_t                 res_n;

  always_comb begin
    pick = (f2_side.cur > 0) ? f2_hi : f2_lo;
    res_n.new_value = f2_side.cur;
    res_n.outcome   = OUT_KEPT;
    if (f2_side.mzero) begin
      res_n.outcome = OUT_NONE;
    end else if ((f2_side.cur != 0) && (mag40(pick) < mag40(f2_side.cur))) begin
      res_n.new_value = pick;
      res_n.outcome   = OUT_ROOT;
    end
  end

  always_ff @(posedge clk) begin
    if (en[NUM_STAGES-1]) result <= res_n;
  end

`ifndef ASSERT_OFF
  a_rst_empty: assert property (@(posedge clk) rst |=> (v == '0))
    else $error("pipeline not empty after reset");
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (cell_valid && !cell_stall) |=> v[0])
    else $error("accepted item missing from first stage");
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    ((v == '1) && result_stall) |-> cell_stall)
    else $error("item taken while the full pipeline is stalled");
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.outcome == OUT_NONE)) |-> (msum == '0))
    else $error("no-solution outcome with nonzero spacings");
  a_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ((result.outcome == OUT_ROOT) || (result.outcome == OUT_KEPT) ||
                      (result.outcome == OUT_NONE)))
    else $error("bad outcome code");
`endif

endmodule
